@@ src/blm_pkg.sv @@
// shared types, constants and threshold table for the battery level monitor
`timescale 1ns / 1ps

package blm_pkg;

    localparam int MAX_CELLS_DEF = 8;
    localparam int ADC_BITS_DEF  = 12;

    localparam int TYPE_W   = 2;
    localparam int GAIN_W   = 24;
    localparam int OFFSET_W = 28;
    localparam int MV_W     = 16;
    localparam int LVL_W    = 2;
    localparam int CELL_W   = 4;
    localparam int THR_W    = 34;
    localparam int ACC_W    = THR_W + CELL_W;
    localparam int SEL_W    = 3;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // millivolt conversion: rounding bias, saturation limit, reciprocal of 15625
    localparam int REM_W     = 36;
    localparam int DIV_SHIFT = 6;
    localparam int RECIP_W   = 31;
    localparam int RECIP_S   = 44;
    localparam logic [REM_W-1:0]   ROUND_NV    = 36'd500000;
    localparam logic [REM_W-1:0]   MV_LIMIT_NV = 36'd65536000000;
    localparam logic [RECIP_W-1:0] RECIP_M     = 31'd1125899907;

    localparam logic [TYPE_W-1:0]   TYPE_RESET   = 2'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd8268490;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 28'd169868000;

    localparam logic [1:0] REG_CHEM_TYPE    = 2'd0;
    localparam logic [1:0] REG_ADC_GAIN     = 2'd1;
    localparam logic [1:0] REG_ADC_OFFSET   = 2'd2;

    localparam logic [TYPE_W-1:0] CHEM_LI_ION = 2'd0;
    localparam logic [TYPE_W-1:0] CHEM_LI_PO  = 2'd1;
    localparam logic [TYPE_W-1:0] CHEM_ALK    = 2'd2;

    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd0;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_OK   = 2'd2;

    localparam logic [SEL_W-1:0] THR_CRIT   = 3'd0;
    localparam logic [SEL_W-1:0] THR_LOW    = 3'd1;
    localparam logic [SEL_W-1:0] THR_FULL   = 3'd2;
    localparam logic [SEL_W-1:0] THR_CRIT_H = 3'd3;
    localparam logic [SEL_W-1:0] THR_LOW_H  = 3'd4;

    typedef struct packed {
        logic            busy;
        logic [MV_W-1:0] mv;
    } div_res_t;

    // per-cell threshold in nanovolts; the unused chemistry code takes the alkaline row
    function automatic logic [THR_W-1:0] thr_nv(input logic [TYPE_W-1:0] chem,
                                                input logic [SEL_W-1:0] sel);
        logic [THR_W-1:0] val;
        val = '0;
        case (chem)
            CHEM_LI_ION:
            begin
                case (sel)
                    THR_CRIT:   val = 34'd3200000000;
                    THR_LOW:    val = 34'd3400000000;
                    THR_FULL:   val = 34'd4300000000;
                    THR_CRIT_H: val = 34'd3400000000;
                    THR_LOW_H:  val = 34'd3600000000;
                    default:    val = '0;
                endcase
            end
            CHEM_LI_PO:
            begin
                case (sel)
                    THR_CRIT:   val = 34'd3400000000;
                    THR_LOW:    val = 34'd3600000000;
                    THR_FULL:   val = 34'd4300000000;
                    THR_CRIT_H: val = 34'd3600000000;
                    THR_LOW_H:  val = 34'd3800000000;
                    default:    val = '0;
                endcase
            end
            default:
            begin
                case (sel)
                    THR_CRIT:   val = 34'd7000000000;
                    THR_LOW:    val = 34'd7500000000;
                    THR_FULL:   val = 34'd9500000000;
                    THR_CRIT_H: val = 34'd7200000000;
                    THR_LOW_H:  val = 34'd7700000000;
                    default:    val = '0;
                endcase
            end
        endcase
        return val;
    endfunction

endpackage

@@ src/blm_ifs.sv @@
// valid/ready channel interfaces for the battery level monitor
`timescale 1ns / 1ps

interface blm_in_if #(
    parameter int ADC_BITS = blm_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                command;
    logic [ADC_BITS-1:0] adc_raw;

    modport source (output valid, output command, output adc_raw, input ready);
    modport sink   (input valid, input command, input adc_raw, output ready);
endinterface

interface blm_out_if;
    logic                         valid;
    logic                         ready;
    logic [blm_pkg::MV_W-1:0]     voltage_mv;
    logic [blm_pkg::LVL_W-1:0]    level;
    logic [blm_pkg::CELL_W-1:0]   cells;

    modport source (output valid, output voltage_mv, output level, output cells, input ready);
    modport sink   (input valid, input voltage_mv, input level, input cells, output ready);
endinterface

@@ src/blm_div.sv @@
// millivolt conversion: rounding, saturation and a registered reciprocal multiply
`timescale 1ns / 1ps

module blm_div #(
    parameter int V_W = blm_pkg::ADC_BITS_DEF + blm_pkg::GAIN_W + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [V_W-1:0]    dividend,
    output blm_pkg::div_res_t res
);

    localparam int IN_W   = (V_W > blm_pkg::REM_W) ? V_W : blm_pkg::REM_W;
    localparam int Y_W    = blm_pkg::REM_W - blm_pkg::DIV_SHIFT;
    localparam int PROD_W = Y_W + blm_pkg::RECIP_W;
    localparam int Q_W    = blm_pkg::MV_W;

    logic             busy_reg, busy_next;
    logic             sat_reg, sat_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [Q_W-1:0]   q_reg, q_next;

    logic [IN_W-1:0]   rem_start;
    logic [PROD_W-1:0] prod;

    assign rem_start = IN_W'(dividend) + IN_W'(blm_pkg::ROUND_NV);
    // nv / 1e6 is (nv / 64) / 15625, the second step by a fixed-point reciprocal
    assign prod      = PROD_W'(y_reg) * PROD_W'(blm_pkg::RECIP_M);

    always_comb
    begin
        busy_next = busy_reg;
        sat_next  = sat_reg;
        y_next    = y_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            // above the 16-bit range the result saturates
            sat_next  = rem_start >= IN_W'(blm_pkg::MV_LIMIT_NV);
            y_next    = rem_start[blm_pkg::REM_W-1:blm_pkg::DIV_SHIFT];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            q_next    = sat_reg ? '1 : prod[blm_pkg::RECIP_S+Q_W-1:blm_pkg::RECIP_S];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        y_reg   <= y_next;
        q_reg   <= q_next;
    end

    assign res.busy = busy_reg;
    assign res.mv   = q_reg;

endmodule

@@ src/battery_level_monitor.sv @@
// battery level monitor top level: register port, sequencer and shared add/compare unit
`timescale 1ns / 1ps
//
// Input channel in_ch carries a command (0 sample, 1 detect cells) and a raw
// converter count; each accepted transfer yields exactly one transfer on out_ch
// with the pack voltage in millivolts, the battery level and the cell count.
// Registers chem_type, adc_gain_nv and adc_offset_nv sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// One item at a time: in_ch.ready is high only while the sequencer is idle.
// From accept to result: the gain multiply, a setup step, the shared adder loop
// and the load of the result; the millivolt conversion runs alongside the loop.
// Detection runs one add/compare step per candidate count (1 to MAX_CELLS);
// alkaline detection skips the loop. A sample adds the threshold once per cell
// and compares, and repeats this for the rise to ok when a low level does not
// fall to critical. The next transfer is taken only after the result loads.
// A finished result waits in the output register while out_ch.ready is low; the
// next item can be accepted meanwhile, and its result holds in the last state
// until the register frees up. Reset restores the register defaults, level ok
// and one cell.
//

module battery_level_monitor #(
    parameter int MAX_CELLS = blm_pkg::MAX_CELLS_DEF,
    parameter int ADC_BITS  = blm_pkg::ADC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    blm_in_if.sink                       in_ch,
    blm_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blm_pkg::PADDR_W-1:0]  paddr,
    input  logic [blm_pkg::PDATA_W-1:0]  pwdata,
    output logic [blm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int V_W   = ADC_BITS + blm_pkg::GAIN_W + 1;
    localparam int CMP_W = (V_W > blm_pkg::ACC_W) ? V_W : blm_pkg::ACC_W;
    localparam int ACC_W = blm_pkg::ACC_W;
    localparam int CELL_W = blm_pkg::CELL_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_DET   = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [blm_pkg::TYPE_W-1:0]   type_reg, type_next;
    logic [blm_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [blm_pkg::OFFSET_W-1:0] offset_reg, offset_next;

    logic [blm_pkg::LVL_W-1:0]    level_reg, level_next;
    logic [CELL_W-1:0]            cells_reg, cells_next;
    logic                         out_valid_reg, out_valid_next;

    logic                         cmd_reg, cmd_next;
    logic [ADC_BITS-1:0]          raw_reg, raw_next;
    logic [V_W-1:0]               v_reg, v_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [CELL_W-1:0]            n_reg, n_next;
    logic [CELL_W-1:0]            cnt_reg, cnt_next;
    logic                         pass_reg, pass_next;
    logic [blm_pkg::MV_W-1:0]     out_mv_reg, out_mv_next;
    logic [blm_pkg::LVL_W-1:0]    out_level_reg, out_level_next;
    logic [CELL_W-1:0]            out_cells_reg, out_cells_next;

    logic                         in_xfer;
    logic                         cfg_wr;
    logic [1:0]                   reg_idx;
    logic                         div_start;
    blm_pkg::div_res_t            div_res;
    logic [blm_pkg::SEL_W-1:0]    thr_sel;
    logic [blm_pkg::THR_W-1:0]    addend;
    logic [ACC_W-1:0]             acc_sum;
    logic                         acc_lt_v;
    logic                         out_free;
    logic                         is_alk;

    assign in_xfer  = in_ch.valid && (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign reg_idx  = paddr[3:2];
    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_alk   = type_reg >= blm_pkg::CHEM_ALK;

    // threshold chosen by the current level and pass of the compare
    always_comb
    begin
        case (level_reg)
            blm_pkg::LVL_CRIT: thr_sel = blm_pkg::THR_CRIT_H;
            blm_pkg::LVL_LOW:  thr_sel = pass_reg ? blm_pkg::THR_LOW_H : blm_pkg::THR_CRIT;
            default:           thr_sel = blm_pkg::THR_LOW;
        endcase
    end

    // shared adder and comparator
    assign addend   = blm_pkg::thr_nv(type_reg,
                                      (state_reg == S_DET) ? blm_pkg::THR_FULL : thr_sel);
    assign acc_sum  = acc_reg + ACC_W'(addend);
    assign acc_lt_v = CMP_W'(acc_reg) < CMP_W'(v_reg);

    assign div_start = (state_reg == S_SETUP);

    blm_div #(
        .V_W (V_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        gain_next      = gain_reg;
        offset_next    = offset_reg;
        level_next     = level_reg;
        cells_next     = cells_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        raw_next       = raw_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        out_mv_next    = out_mv_reg;
        out_level_next = out_level_reg;
        out_cells_next = out_cells_reg;

        if (cfg_wr)
        begin
            unique case (reg_idx)
                blm_pkg::REG_CHEM_TYPE:    type_next   = pwdata[blm_pkg::TYPE_W-1:0];
                blm_pkg::REG_ADC_GAIN:     gain_next   = pwdata[blm_pkg::GAIN_W-1:0];
                blm_pkg::REG_ADC_OFFSET:   offset_next = pwdata[blm_pkg::OFFSET_W-1:0];
                default:                   ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = in_ch.command;
                    raw_next   = in_ch.adc_raw;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                v_next     = V_W'(raw_reg) * V_W'(gain_reg) + V_W'(offset_reg);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (cmd_reg)
                begin
                    n_next   = CELL_W'(1);
                    acc_next = ACC_W'(blm_pkg::thr_nv(type_reg, blm_pkg::THR_FULL));
                    state_next = is_alk ? S_DONE : S_DET;
                end
                else
                begin
                    acc_next  = '0;
                    cnt_next  = cells_reg;
                    pass_next = 1'b0;
                    state_next = (level_reg == blm_pkg::LVL_CRIT ||
                                  level_reg == blm_pkg::LVL_LOW ||
                                  level_reg == blm_pkg::LVL_OK) ? S_ACC : S_DONE;
                end
            end
            S_DET:
            begin
                if ((n_reg < CELL_W'(MAX_CELLS)) && acc_lt_v)
                begin
                    n_next   = n_reg + 1'b1;
                    acc_next = acc_sum;
                end
                else
                begin
                    cells_next = n_reg;
                    state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                // threshold times cell count by repeated addition
                if (cnt_reg != '0)
                begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DONE;
                case (level_reg)
                    blm_pkg::LVL_CRIT:
                    begin
                        if (acc_lt_v)
                        begin
                            level_next = blm_pkg::LVL_LOW;
                        end
                    end
                    blm_pkg::LVL_LOW:
                    begin
                        if (!pass_reg)
                        begin
                            if (!acc_lt_v)
                            begin
                                level_next = blm_pkg::LVL_CRIT;
                            end
                            else
                            begin
                                // not critical: try the rise to ok
                                pass_next  = 1'b1;
                                acc_next   = '0;
                                cnt_next   = cells_reg;
                                state_next = S_ACC;
                            end
                        end
                        else if (acc_lt_v)
                        begin
                            level_next = blm_pkg::LVL_OK;
                        end
                    end
                    blm_pkg::LVL_OK:
                    begin
                        if (!acc_lt_v)
                        begin
                            level_next = blm_pkg::LVL_LOW;
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE:
            begin
                if (!div_res.busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mv_next    = div_res.mv;
                    out_level_next = level_reg;
                    out_cells_next = cells_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            type_reg      <= blm_pkg::TYPE_RESET;
            gain_reg      <= blm_pkg::GAIN_RESET;
            offset_reg    <= blm_pkg::OFFSET_RESET;
            level_reg     <= blm_pkg::LVL_OK;
            cells_reg     <= CELL_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            type_reg      <= type_next;
            gain_reg      <= gain_next;
            offset_reg    <= offset_next;
            level_reg     <= level_next;
            cells_reg     <= cells_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        raw_reg       <= raw_next;
        v_reg         <= v_next;
        acc_reg       <= acc_next;
        n_reg         <= n_next;
        cnt_reg       <= cnt_next;
        pass_reg      <= pass_next;
        out_mv_reg    <= out_mv_next;
        out_level_reg <= out_level_next;
        out_cells_reg <= out_cells_next;
    end

    always_comb
    begin
        unique case (reg_idx)
            blm_pkg::REG_CHEM_TYPE:    prdata = blm_pkg::PDATA_W'(type_reg);
            blm_pkg::REG_ADC_GAIN:     prdata = blm_pkg::PDATA_W'(gain_reg);
            blm_pkg::REG_ADC_OFFSET:   prdata = blm_pkg::PDATA_W'(offset_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.voltage_mv = out_mv_reg;
    assign out_ch.level      = out_level_reg;
    assign out_ch.cells      = out_cells_reg;

endmodule

@@ src/blm_checker.sv @@
// port-level checks for the battery level monitor, bound to the top level
`timescale 1ns / 1ps

module blm_checker #(
    parameter int MAX_CELLS = blm_pkg::MAX_CELLS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [blm_pkg::MV_W-1:0]     voltage_mv,
    input logic [blm_pkg::LVL_W-1:0]    level,
    input logic [blm_pkg::CELL_W-1:0]   cells
);

    // one item in flight: no new transfer right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level == blm_pkg::LVL_CRIT || level == blm_pkg::LVL_LOW ||
                       level == blm_pkg::LVL_OK))
        else $error("result level out of range");

    a_cells_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cells != '0 && cells <= blm_pkg::CELL_W'(MAX_CELLS)))
        else $error("result cell count out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(voltage_mv) && $stable(level) && $stable(cells))
        else $error("result changed while stalled");

endmodule

bind battery_level_monitor blm_checker #(
    .MAX_CELLS (MAX_CELLS)
) u_blm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .voltage_mv (out_ch.voltage_mv),
    .level      (out_ch.level),
    .cells      (out_ch.cells)
);

@@ tb/tb_top.sv @@
// self-checking testbench for the battery level monitor: apb setup, stream driver, result checker
`timescale 1ns / 1ps

module tb_top;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    localparam int MAX_CELLS  = blm_pkg::MAX_CELLS_DEF;
    localparam int RAW_MAX    = (1 << blm_pkg::ADC_BITS_DEF) - 1;
    localparam int IDLE_PCT   = 34;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 212;

    localparam logic [63:0] HYST_NV = 64'd200000000;

    typedef struct packed {
        logic                             cmd;
        logic [blm_pkg::ADC_BITS_DEF-1:0] raw;
    } sample_item_t;

    typedef struct packed {
        logic [blm_pkg::MV_W-1:0]   mv;
        logic [blm_pkg::LVL_W-1:0]  level;
        logic [blm_pkg::CELL_W-1:0] cells;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [blm_pkg::PADDR_W-1:0] paddr = '0;
    logic [blm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [blm_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    logic                             drv_valid = 1'b0;
    logic                             drv_cmd = CMD_SAMPLE;
    logic [blm_pkg::ADC_BITS_DEF-1:0] drv_raw = '0;
    logic                             mon_ready = 1'b0;
    logic                             steady = 1'b0;

    // shadow of the block's registers and state
    logic [blm_pkg::TYPE_W-1:0]   sh_type   = blm_pkg::TYPE_RESET;
    logic [blm_pkg::GAIN_W-1:0]   sh_gain   = blm_pkg::GAIN_RESET;
    logic [blm_pkg::OFFSET_W-1:0] sh_offset = blm_pkg::OFFSET_RESET;
    logic [blm_pkg::LVL_W-1:0]    sh_level  = blm_pkg::LVL_OK;
    logic [blm_pkg::CELL_W-1:0]   sh_cells  = 4'd1;

    sample_item_t pending_items[$];
    reading_t     expected_readings[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;

    blm_in_if  in_ch ();
    blm_out_if out_ch ();

    assign in_ch.valid   = drv_valid;
    assign in_ch.command = drv_cmd;
    assign in_ch.adc_raw = drv_raw;
    assign out_ch.ready  = mon_ready;

    battery_level_monitor uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // pack voltage, level machine and cell count for one item
    function automatic reading_t predict_reading(input sample_item_t it);
        reading_t                   r;
        logic [blm_pkg::TYPE_W-1:0] row;
        logic [63:0]      v;
        logic [63:0]      n64;
        logic [63:0]      crit;
        logic [63:0]      low;
        logic [63:0]      full;
        logic [63:0]      mv;
        int               n;
        row = (sh_type == blm_pkg::CHEM_LI_ION || sh_type == blm_pkg::CHEM_LI_PO) ?
              sh_type : blm_pkg::CHEM_ALK;
        case (row)
            blm_pkg::CHEM_LI_ION:
            begin
                crit = 64'd3200000000;
                low  = 64'd3400000000;
                full = 64'd4300000000;
            end
            blm_pkg::CHEM_LI_PO:
            begin
                crit = 64'd3400000000;
                low  = 64'd3600000000;
                full = 64'd4300000000;
            end
            default:
            begin
                crit = 64'd7000000000;
                low  = 64'd7500000000;
                full = 64'd9500000000;
            end
        endcase
        v = 64'(it.raw) * 64'(sh_gain) + 64'(sh_offset);
        if (it.cmd == CMD_DETECT)
        begin
            if (row != blm_pkg::CHEM_ALK)
            begin
                n = 1;
                while (n < MAX_CELLS && 64'(n) * full < v)
                    n++;
                sh_cells = blm_pkg::CELL_W'(n);
            end
        end
        else
        begin
            n64 = 64'(sh_cells);
            case (sh_level)
                blm_pkg::LVL_CRIT:
                begin
                    if (v > n64 * (crit + HYST_NV))
                        sh_level = blm_pkg::LVL_LOW;
                end
                blm_pkg::LVL_LOW:
                begin
                    if (v <= n64 * crit)
                        sh_level = blm_pkg::LVL_CRIT;
                    else if (v > n64 * (low + HYST_NV))
                        sh_level = blm_pkg::LVL_OK;
                end
                blm_pkg::LVL_OK:
                begin
                    if (v <= n64 * low)
                        sh_level = blm_pkg::LVL_LOW;
                end
                default:
                begin
                end
            endcase
        end
        mv = (v + 64'd500000) / 64'd1000000;
        if (mv > 64'd65535)
            mv = 64'd65535;
        r.mv    = mv[blm_pkg::MV_W-1:0];
        r.level = sh_level;
        r.cells = sh_cells;
        return r;
    endfunction

    // input side: holds an offered item until its transfer, then maybe idles
    always @(posedge clk)
    begin : driver
        sample_item_t nxt;
        if (rst_n)
        begin
            if (drv_valid && in_ch.ready)
                expected_readings.push_back(predict_reading('{cmd: drv_cmd, raw: drv_raw}));
            if (!(drv_valid && !in_ch.ready))
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    drv_valid <= 1'b1;
                    drv_cmd   <= nxt.cmd;
                    drv_raw   <= nxt.raw;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // output side: random backpressure and check against the oldest prediction
    always @(posedge clk)
    begin : monitor
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (out_ch.valid && mon_ready)
            begin
                got = '{mv: out_ch.voltage_mv, level: out_ch.level, cells: out_ch.cells};
                if (expected_readings.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with none expected: mv %0d level %0d cells %0d",
                                 $realtime, got.mv, got.level, got.cells);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.mv !== want.mv || got.level !== want.level
                        || got.cells !== want.cells)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: mv %0d/%0d level %0d/%0d cells %0d/%0d",
                                     $realtime, want.mv, got.mv, want.level, got.level,
                                     want.cells, got.cells);
                        mismatches++;
                    end
                end
            end
            mon_ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((drv_valid && in_ch.ready) || (out_ch.valid && mon_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input int raw);
        pending_items.push_back('{cmd: cmd, raw: blm_pkg::ADC_BITS_DEF'(raw)});
    endtask

    // wait until every item has gone in and every result has come out
    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || drv_valid || expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx,
                             input logic [blm_pkg::PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            blm_pkg::REG_CHEM_TYPE:  sh_type   = val[blm_pkg::TYPE_W-1:0];
            blm_pkg::REG_ADC_GAIN:   sh_gain   = val[blm_pkg::GAIN_W-1:0];
            blm_pkg::REG_ADC_OFFSET: sh_offset = val[blm_pkg::OFFSET_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input int chem, input int gain, input int offset);
        drain();
        repeat (5) @(posedge clk);
        reg_write(blm_pkg::REG_CHEM_TYPE, blm_pkg::PDATA_W'(chem));
        reg_write(blm_pkg::REG_ADC_GAIN, blm_pkg::PDATA_W'(gain));
        reg_write(blm_pkg::REG_ADC_OFFSET, blm_pkg::PDATA_W'(offset));
    endtask

    // grid raws land on or one count beside 200 mV steps when the gain is 8 mV per count
    task automatic add_random_items(input int count, input bit grid);
        int  raw;
        logic cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(99) < 20) ? CMD_DETECT : CMD_SAMPLE;
            if (grid && $urandom_range(99) < 70)
                raw = 25 * $urandom_range(163, 1) + $urandom_range(2) - 1;
            else if ($urandom_range(99) < 4)
                raw = $urandom_range(1) ? RAW_MAX : 0;
            else
                raw = $urandom_range(RAW_MAX);
            push_item(cmd, raw);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults
        push_item(CMD_DETECT, RAW_MAX);
        push_item(CMD_SAMPLE, 0);

        // 2 mV per count: exact threshold hits for one cell
        set_config(blm_pkg::CHEM_LI_ION, 2000000, 0);
        push_item(CMD_DETECT, 2151);
        push_item(CMD_DETECT, 2150);
        push_item(CMD_SAMPLE, 1700);
        push_item(CMD_SAMPLE, 1800);
        push_item(CMD_SAMPLE, 1801);
        push_item(CMD_SAMPLE, 1600);
        push_item(CMD_SAMPLE, 1600);
        push_item(CMD_SAMPLE, 1700);
        push_item(CMD_SAMPLE, 1701);
        push_item(CMD_DETECT, 0);
        push_item(CMD_SAMPLE, RAW_MAX);

        // voltage and cell count saturation
        set_config(blm_pkg::CHEM_LI_PO, (1 << blm_pkg::GAIN_W) - 1,
                   (1 << blm_pkg::OFFSET_W) - 1);
        push_item(CMD_DETECT, RAW_MAX);
        push_item(CMD_SAMPLE, RAW_MAX);
        push_item(CMD_DETECT, 0);

        // unused chemistry code behaves as alkaline, detect leaves cells alone
        set_config(3, (1 << blm_pkg::GAIN_W) - 1, (1 << blm_pkg::OFFSET_W) - 1);
        push_item(CMD_DETECT, RAW_MAX);
        push_item(CMD_SAMPLE, 0);
        set_config(blm_pkg::CHEM_ALK, 0, 0);
        push_item(CMD_SAMPLE, 0);
        push_item(CMD_DETECT, RAW_MAX);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_config(blm_pkg::CHEM_LI_ION, blm_pkg::GAIN_RESET, blm_pkg::OFFSET_RESET);
                1: set_config(blm_pkg::CHEM_LI_ION, 8000000, 0);
                2: set_config(blm_pkg::CHEM_LI_PO, 8000000, 0);
                3: set_config(blm_pkg::CHEM_ALK, 8000000, 0);
                4: set_config(3, 8000000, 0);
                5: set_config($urandom_range(3), (1 << blm_pkg::GAIN_W) - 1,
                              (1 << blm_pkg::OFFSET_W) - 1);
                6: set_config($urandom_range(3), 0,
                              $urandom_range((1 << blm_pkg::OFFSET_W) - 1));
                default: set_config($urandom_range(3),
                                    $urandom_range((1 << blm_pkg::GAIN_W) - 1),
                                    $urandom_range((1 << blm_pkg::OFFSET_W) - 1));
            endcase
            steady = (ph == 1);
            add_random_items(PHASE_ITEMS, ph >= 1 && ph <= 4);
        end

        drain();
        steady = 1'b0;
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
